/* sv/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the header parser checks.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is ignored while reset is asserted.
`define L4P_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define L4P_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* sv/eth_l4p_pkg.sv */
// ---------------------------------------------------------------------------
// Header parser package
// Request types, protocol constants and class codes shared by the parser.
// ---------------------------------------------------------------------------
`default_nettype none

package eth_l4p_pkg;

  localparam int unsigned L4P_COUNT_WIDTH      = 32;
  localparam int unsigned L4P_BYTE_COUNT_WIDTH = 48;

  localparam logic [15:0] ETH_HDR_BYTES     = 16'd14;
  localparam logic [15:0] ETH_TYPE_HI_POS   = 16'd12;
  localparam logic [15:0] ETH_TYPE_LO_POS   = 16'd13;
  localparam logic [15:0] IP_IHL_POS        = 16'd14;
  localparam logic [15:0] IP_PROTO_POS      = 16'd23;
  localparam logic [15:0] IP_SRC_POS        = 16'd26;
  localparam logic [15:0] IP_DST_POS        = 16'd30;
  localparam logic [15:0] IP_END_POS        = 16'd33;
  localparam logic [15:0] ETHERTYPE_IPV4    = 16'h0800;
  localparam logic [3:0]  IHL_MIN_WORDS     = 4'd5;
  localparam logic [7:0]  PROTO_TCP         = 8'd6;
  localparam logic [7:0]  PROTO_UDP         = 8'd17;
  localparam logic [7:0]  PROTO_ICMP        = 8'd1;
  localparam logic [6:0]  TCP_FLAG_BYTE_OFS = 7'd13;

  typedef enum logic [2:0] {
    CLS_RUNT     = 3'd0,
    CLS_NON_IPV4 = 3'd1,
    CLS_TCP      = 3'd2,
    CLS_UDP      = 3'd3,
    CLS_ICMP     = 3'd4,
    CLS_OTHER_IP = 3'd5
  } frame_class_e;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [15:0] wire_length;
  } eth_l4p_in_t;

  typedef struct packed {
    frame_class_e frame_class;
    logic [31:0]  source_address;
    logic [31:0]  dest_address;
    logic [7:0]   ip_protocol;
    logic [15:0]  source_port;
    logic [15:0]  dest_port;
    logic [7:0]   tcp_flag_bits;
    logic [31:0]  frames_seen;
    logic [31:0]  class_total;
    logic [47:0]  bytes_seen;
  } eth_l4p_out_t;

  typedef struct packed {
    frame_class_e frame_class;
    logic [31:0]  source_address;
    logic [31:0]  dest_address;
    logic [7:0]   ip_protocol;
    logic [15:0]  source_port;
    logic [15:0]  dest_port;
    logic [7:0]   tcp_flag_bits;
  } eth_l4p_hdr_t;

  typedef struct packed {
    logic [31:0] frames_seen;
    logic [31:0] class_total;
    logic [47:0] bytes_seen;
  } eth_l4p_stats_t;

endpackage

`default_nettype wire

/* sv/eth_l4p_field_parser.sv */
// ---------------------------------------------------------------------------
// Header field parser
// Tracks the byte position and captures Ethernet, IPv4 and L4 header fields.
// ---------------------------------------------------------------------------
`default_nettype none

module eth_l4p_field_parser
  import eth_l4p_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         step_i,
  input  wire logic [7:0]   data_byte_i,
  input  wire logic         last_byte_i,
  output eth_l4p_hdr_t      hdr_o
);

  logic [15:0] pos_q, pos_d;
  logic [15:0] ether_kind_q, ether_kind_d;
  logic [3:0]  hdr_words_q, hdr_words_d;
  logic [7:0]  proto_q, proto_d;
  logic [31:0] src_q, src_d;
  logic [31:0] dst_q, dst_d;
  logic [15:0] sport_q, sport_d;
  logic [15:0] dport_q, dport_d;
  logic [7:0]  flags_q, flags_d;
  logic [3:0]  hw_eff;
  logic [6:0]  l4_ofs;
  logic [15:0] l4_pos;
  logic        is_tcp, is_udp;

  always_comb begin
    ether_kind_d = ether_kind_q;
    hdr_words_d  = hdr_words_q;
    proto_d      = proto_q;
    src_d        = src_q;
    dst_d        = dst_q;
    sport_d      = sport_q;
    dport_d      = dport_q;
    flags_d      = flags_q;

    if (pos_q == ETH_TYPE_HI_POS) begin
      ether_kind_d[15:8] = data_byte_i;
    end
    if (pos_q == ETH_TYPE_LO_POS) begin
      ether_kind_d[7:0] = data_byte_i;
    end
    if (pos_q == IP_IHL_POS) begin
      hdr_words_d = data_byte_i[3:0];
    end
    if (pos_q == IP_PROTO_POS) begin
      proto_d = data_byte_i;
    end
    if (pos_q >= IP_SRC_POS && pos_q < IP_DST_POS) begin
      src_d = {src_q[23:0], data_byte_i};
    end
    if (pos_q >= IP_DST_POS && pos_q <= IP_END_POS) begin
      dst_d = {dst_q[23:0], data_byte_i};
    end

    hw_eff = (hdr_words_d < IHL_MIN_WORDS) ? IHL_MIN_WORDS : hdr_words_d;
    l4_ofs = 7'(ETH_HDR_BYTES) + {1'b0, hw_eff, 2'b00};
    l4_pos = 16'(l4_ofs);

    if (pos_q == l4_pos || pos_q == l4_pos + 16'd1) begin
      sport_d = {sport_q[7:0], data_byte_i};
    end
    if (pos_q == l4_pos + 16'd2 || pos_q == l4_pos + 16'd3) begin
      dport_d = {dport_q[7:0], data_byte_i};
    end
    if (pos_q == l4_pos + 16'(TCP_FLAG_BYTE_OFS)) begin
      flags_d = data_byte_i;
    end

    if (last_byte_i) begin
      pos_d = '0;
    end else if (pos_q != 16'hFFFF) begin
      pos_d = pos_q + 16'd1;
    end else begin
      pos_d = pos_q;
    end
  end

  always_comb begin
    hdr_o = '0;
    if (pos_q < ETH_TYPE_LO_POS) begin
      hdr_o.frame_class = CLS_RUNT;
    end else if (ether_kind_d != ETHERTYPE_IPV4) begin
      hdr_o.frame_class = CLS_NON_IPV4;
    end else if (pos_q < IP_END_POS) begin
      hdr_o.frame_class = CLS_RUNT;
    end else if (proto_d == PROTO_TCP) begin
      hdr_o.frame_class = CLS_TCP;
    end else if (proto_d == PROTO_UDP) begin
      hdr_o.frame_class = CLS_UDP;
    end else if (proto_d == PROTO_ICMP) begin
      hdr_o.frame_class = CLS_ICMP;
    end else begin
      hdr_o.frame_class = CLS_OTHER_IP;
    end

    is_tcp = (hdr_o.frame_class == CLS_TCP);
    is_udp = (hdr_o.frame_class == CLS_UDP);

    if (hdr_o.frame_class != CLS_RUNT && hdr_o.frame_class != CLS_NON_IPV4) begin
      hdr_o.source_address = src_d;
      hdr_o.dest_address   = dst_d;
      hdr_o.ip_protocol    = proto_d;
    end
    if ((is_tcp || is_udp) && pos_q >= l4_pos + 16'd1) begin
      hdr_o.source_port = sport_d;
    end
    if ((is_tcp || is_udp) && pos_q >= l4_pos + 16'd3) begin
      hdr_o.dest_port = dport_d;
    end
    if (is_tcp && pos_q >= l4_pos + 16'(TCP_FLAG_BYTE_OFS)) begin
      hdr_o.tcp_flag_bits = flags_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      ether_kind_q <= '0;
      hdr_words_q  <= '0;
      proto_q      <= '0;
      src_q        <= '0;
      dst_q        <= '0;
      sport_q      <= '0;
      dport_q      <= '0;
      flags_q      <= '0;
    end else if (step_i) begin
      pos_q        <= pos_d;
      ether_kind_q <= ether_kind_d;
      hdr_words_q  <= hdr_words_d;
      proto_q      <= proto_d;
      src_q        <= src_d;
      dst_q        <= dst_d;
      sport_q      <= sport_d;
      dport_q      <= dport_d;
      flags_q      <= flags_d;
    end
  end

endmodule

`default_nettype wire

/* sv/eth_l4p_stats.sv */
// ---------------------------------------------------------------------------
// Traffic statistics
// Saturating frame, per-class and wire byte counters updated at frame end.
// ---------------------------------------------------------------------------
`default_nettype none

module eth_l4p_stats
  import eth_l4p_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH      = L4P_COUNT_WIDTH,
  parameter int unsigned BYTE_COUNT_WIDTH = L4P_BYTE_COUNT_WIDTH
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         update_i,
  input  frame_class_e      frame_class_i,
  input  wire logic [15:0]  wire_length_i,
  output eth_l4p_stats_t    stats_o
);

  typedef enum logic [1:0] {
    GRP_TCP   = 2'd0,
    GRP_UDP   = 2'd1,
    GRP_ICMP  = 2'd2,
    GRP_OTHER = 2'd3
  } group_e;

  logic [COUNT_WIDTH-1:0]      total_q, total_d;
  logic [COUNT_WIDTH-1:0]      grp_q [4];
  logic [COUNT_WIDTH-1:0]      grp_d;
  logic [BYTE_COUNT_WIDTH-1:0] bytes_q, bytes_d;
  logic [BYTE_COUNT_WIDTH:0]   bytes_sum;
  logic [63:0]                 total_ext, grp_ext, bytes_ext;
  group_e                      grp;

  always_comb begin
    case (frame_class_i)
      CLS_TCP:  grp = GRP_TCP;
      CLS_UDP:  grp = GRP_UDP;
      CLS_ICMP: grp = GRP_ICMP;
      default:  grp = GRP_OTHER;
    endcase

    total_d = (total_q == '1) ? total_q : total_q + 1'b1;
    grp_d   = (grp_q[grp] == '1) ? grp_q[grp] : grp_q[grp] + 1'b1;

    bytes_sum = {1'b0, bytes_q} + (BYTE_COUNT_WIDTH+1)'(wire_length_i);
    bytes_d   = bytes_sum[BYTE_COUNT_WIDTH] ? '1 : bytes_sum[BYTE_COUNT_WIDTH-1:0];

    total_ext = 64'(total_d);
    grp_ext   = 64'(grp_d);
    bytes_ext = 64'(bytes_d);

    stats_o.frames_seen = total_ext[31:0];
    stats_o.class_total = grp_ext[31:0];
    stats_o.bytes_seen  = bytes_ext[47:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      bytes_q <= '0;
      for (int i = 0; i < 4; i++) begin
        grp_q[i] <= '0;
      end
    end else if (update_i) begin
      total_q    <= total_d;
      bytes_q    <= bytes_d;
      grp_q[grp] <= grp_d;
    end
  end

endmodule

`default_nettype wire

/* sv/eth_ipv4_l4_header_parser_core.sv */
// ---------------------------------------------------------------------------
// Ethernet IPv4 L4 header parser core
// Parses a captured frame byte by byte and emits one header and traffic
// record per frame.
// ---------------------------------------------------------------------------
//  Channel | Direction | Handshake              | Payload
//  in      | input     | in_valid_i/in_stall_o   | eth_l4p_in_t, one byte per request
//  out     | output    | out_valid_o/out_stall_i | eth_l4p_out_t, one per frame
//
// One byte is taken every cycle unless in_stall_o is high; the parse and counter
// update are combinational from the input register to the record register.
// A record is registered when the input register advances with its last byte.
// Reset clears the byte position, the captured fields and all counters.
// A stalled record holds the input only while the input register holds a last byte.
// ---------------------------------------------------------------------------
`default_nettype none

module eth_ipv4_l4_header_parser_core
  import eth_l4p_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH      = L4P_COUNT_WIDTH,
  parameter int unsigned BYTE_COUNT_WIDTH = L4P_BYTE_COUNT_WIDTH
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   in_valid_i,
  output logic        in_stall_o,
  input  eth_l4p_in_t in_req_i,
  output logic        out_valid_o,
  input  wire logic   out_stall_i,
  output eth_l4p_out_t out_req_o
);

  logic           s1_valid_q, s1_valid_d;
  eth_l4p_in_t    s1_req_q;
  logic           s1_adv, s1_emit, in_take;
  logic           out_valid_q, out_valid_d;
  eth_l4p_out_t   out_req_q;
  eth_l4p_hdr_t   hdr;
  eth_l4p_stats_t stats;

  assign s1_emit    = s1_valid_q && s1_req_q.last_byte;
  assign s1_adv     = s1_valid_q && (!s1_req_q.last_byte || !out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_take    = in_valid_i && !in_stall_o;

  eth_l4p_field_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (s1_adv),
    .data_byte_i (s1_req_q.data_byte),
    .last_byte_i (s1_req_q.last_byte),
    .hdr_o       (hdr)
  );

  eth_l4p_stats #(
    .COUNT_WIDTH      (COUNT_WIDTH),
    .BYTE_COUNT_WIDTH (BYTE_COUNT_WIDTH)
  ) u_stats (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .update_i      (s1_adv && s1_emit),
    .frame_class_i (hdr.frame_class),
    .wire_length_i (s1_req_q.wire_length),
    .stats_o       (stats)
  );

  always_comb begin
    s1_valid_d = in_take || (s1_valid_q && !s1_adv);
    if (s1_adv && s1_emit) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_req_q <= in_req_i;
    end
    if (s1_adv && s1_emit) begin
      out_req_q.frame_class    <= hdr.frame_class;
      out_req_q.source_address <= hdr.source_address;
      out_req_q.dest_address   <= hdr.dest_address;
      out_req_q.ip_protocol    <= hdr.ip_protocol;
      out_req_q.source_port    <= hdr.source_port;
      out_req_q.dest_port      <= hdr.dest_port;
      out_req_q.tcp_flag_bits  <= hdr.tcp_flag_bits;
      out_req_q.frames_seen    <= stats.frames_seen;
      out_req_q.class_total    <= stats.class_total;
      out_req_q.bytes_seen     <= stats.bytes_seen;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_req_q;

endmodule

`default_nettype wire

/* sv/eth_l4p_checker.sv */
// ---------------------------------------------------------------------------
// Header parser port checker
// Checks on the output records as seen at the top-level ports.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module eth_l4p_checker
  import eth_l4p_pkg::*;
(
  input wire logic   clk_i,
  input wire logic   rst_ni,
  input wire logic   in_stall_o,
  input wire logic   out_valid_o,
  input wire logic   out_stall_i,
  input eth_l4p_out_t out_req_o
);

  logic non_ip, l4_class;

  assign non_ip   = (out_req_o.frame_class == CLS_RUNT) ||
                    (out_req_o.frame_class == CLS_NON_IPV4);
  assign l4_class = (out_req_o.frame_class == CLS_TCP) ||
                    (out_req_o.frame_class == CLS_UDP);

  `L4P_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_req_o), "Stalled record changed")
  `L4P_ASSERT(a_non_ip_zero, out_valid_o && non_ip |-> out_req_o.source_address == 32'd0 && out_req_o.dest_address == 32'd0 && out_req_o.ip_protocol == 8'd0, "Non-IPv4 record carries IP fields")
  `L4P_ASSERT(a_ports_zero, out_valid_o && !l4_class |-> out_req_o.source_port == 16'd0 && out_req_o.dest_port == 16'd0, "Ports set on a non-TCP/UDP record")
  `L4P_ASSERT(a_flags_zero, out_valid_o && out_req_o.frame_class != CLS_TCP |-> out_req_o.tcp_flag_bits == 8'd0, "Flags set on a non-TCP record")
  `L4P_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> !out_valid_o && !in_stall_o, "Record or stall during reset")

endmodule

bind eth_ipv4_l4_header_parser_core eth_l4p_checker u_eth_l4p_checker (.*);

`default_nettype wire
